>>> rtl/core/via_pkg.sv
// Package for the timer 2 and interrupt subset of the interface adapter.
// Holds operation codes, the register map, widths, flag bit positions, port masks and shared types.
// No dependencies.
`default_nettype none

package via_pkg;

   // Operation carried by one input transaction.
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // Register select map.
   localparam logic [3:0] REG_ORB  = 4'd0;
   localparam logic [3:0] REG_ORA  = 4'd1;
   localparam logic [3:0] REG_DDRB = 4'd2;
   localparam logic [3:0] REG_DDRA = 4'd3;
   localparam logic [3:0] REG_T2L  = 4'd8;
   localparam logic [3:0] REG_T2H  = 4'd9;
   localparam logic [3:0] REG_ACR  = 4'd11;
   localparam logic [3:0] REG_PCR  = 4'd12;
   localparam logic [3:0] REG_IFR  = 4'd13;
   localparam logic [3:0] REG_IER  = 4'd14;
   localparam logic [3:0] REG_ORAN = 4'd15;

   // Widths and masks.
   localparam int unsigned LATCH_W   = 16;
   localparam int unsigned FLAG_W    = 7;
   localparam int unsigned T2_BIT    = 5;
   localparam int unsigned IER_SET   = 7;
   localparam logic [7:0]  ORB_MASK  = 8'h1f;
   localparam logic [7:0]  ORB_FORCE = 8'h40;

   // Commands from the register file to the timer 2 counter.
   typedef struct packed {
      logic tick;
      logic load;
   } t2_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/via_timer2.sv
// Timer 2 tick countdown with reload from the 16-bit latch.
// Depends on via_pkg for the control struct and latch width.
`default_nettype none

module via_timer2
   import via_pkg::*;
#(
   parameter int unsigned PRESCALE_SHIFT = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire t2_ctl_type         ctl,
   input  wire logic [LATCH_W-1:0] latch_next,
   output logic                    expire
);

   localparam int unsigned CNT_W = LATCH_W - PRESCALE_SHIFT;

   logic [CNT_W-1:0] ticks_left_ff;
   logic [CNT_W-1:0] ticks_left_in;
   logic [CNT_W-1:0] reload;
   logic [CNT_W-1:0] ticks_dec;

   // The reload value is the latch divided down by the prescaler.
   assign reload = latch_next[LATCH_W-1:PRESCALE_SHIFT];

   // A tick decrements a nonzero count; reaching zero is an expiry.
   assign ticks_dec = (ticks_left_ff == '0) ? ticks_left_ff : ticks_left_ff - CNT_W'(1);
   assign expire    = ctl.tick && (ticks_dec == '0);

   // Next count: a latch write reloads, an expiry reloads, otherwise count down.
   always_comb begin
      ticks_left_in = ticks_left_ff;
      if (ctl.load) begin
         ticks_left_in = reload;
      end else if (ctl.tick) begin
         ticks_left_in = expire ? reload : ticks_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_left_ff <= '0;
      end else begin
         ticks_left_ff <= ticks_left_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/via_regs.sv
// Register file of the adapter subset: ports, direction registers, timer 2
// latches, ACR, PCR, interrupt flags and enables, and the read multiplexer.
// Depends on via_pkg for the register map, masks and timer control struct.
`default_nettype none

module via_regs
   import via_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [1:0]         op,
   input  wire logic [3:0]         reg_addr,
   input  wire logic [7:0]         write_data,
   input  wire logic               expire,
   output t2_ctl_type              t2_ctl,
   output logic [LATCH_W-1:0]      latch_next,
   output logic [7:0]              read_data,
   output logic                    irq_next
);

   logic [7:0]        port_b_out_ff, port_b_out_in;
   logic [7:0]        port_a_out_ff, port_a_out_in;
   logic [7:0]        dir_a_ff, dir_a_in;
   logic [7:0]        dir_b_ff, dir_b_in;
   logic [7:0]        t2_latch_low_ff, t2_latch_low_in;
   logic [7:0]        t2_latch_high_ff, t2_latch_high_in;
   logic [7:0]        aux_control_ff, aux_control_in;
   logic [7:0]        periph_control_ff, periph_control_in;
   logic [FLAG_W-1:0] flag_bits_ff, flag_bits_in;
   logic [FLAG_W-1:0] enable_bits_ff, enable_bits_in;
   logic              irq_now;
   logic [7:0]        read_mux;
   logic              is_tick;
   logic              is_read;
   logic              is_write;

   assign is_tick  = (op == OP_TICK);
   assign is_read  = (op == OP_READ);
   assign is_write = (op == OP_WRITE);

   // Timer commands: a tick counts, a write to either latch byte reloads.
   assign t2_ctl.tick = fire && is_tick;
   assign t2_ctl.load = fire && is_write && ((reg_addr == REG_T2L) || (reg_addr == REG_T2H));
   assign latch_next  = {t2_latch_high_in, t2_latch_low_in};

   // Next state of the register file for the transaction being processed.
   always_comb begin
      port_b_out_in     = port_b_out_ff;
      port_a_out_in     = port_a_out_ff;
      dir_a_in          = dir_a_ff;
      dir_b_in          = dir_b_ff;
      t2_latch_low_in   = t2_latch_low_ff;
      t2_latch_high_in  = t2_latch_high_ff;
      aux_control_in    = aux_control_ff;
      periph_control_in = periph_control_ff;
      flag_bits_in      = flag_bits_ff;
      enable_bits_in    = enable_bits_ff;
      if (fire && is_tick) begin
         if (expire && enable_bits_ff[T2_BIT]) begin
            flag_bits_in[T2_BIT] = 1'b1;
         end
      end else if (fire && is_write) begin
         case (reg_addr)
            REG_ORB:  port_b_out_in = write_data;
            REG_ORA,
            REG_ORAN: port_a_out_in = write_data;
            REG_DDRB: dir_b_in = write_data;
            REG_DDRA: dir_a_in = write_data;
            REG_T2L:  t2_latch_low_in = write_data;
            REG_T2H: begin
               t2_latch_high_in     = write_data;
               flag_bits_in[T2_BIT] = 1'b0;
            end
            REG_ACR:  aux_control_in = write_data;
            REG_PCR:  periph_control_in = write_data;
            REG_IFR:  flag_bits_in = flag_bits_ff & ~write_data[FLAG_W-1:0];
            REG_IER: begin
               if (write_data[IER_SET]) begin
                  enable_bits_in = enable_bits_ff | write_data[FLAG_W-1:0];
               end else begin
                  enable_bits_in = enable_bits_ff & ~write_data[FLAG_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   // Read multiplexer on the current state; reads change nothing.
   assign irq_now = |(flag_bits_ff & enable_bits_ff);

   always_comb begin
      case (reg_addr)
         REG_ORB:  read_mux = (port_b_out_ff & ORB_MASK) | ORB_FORCE;
         REG_ORA,
         REG_ORAN: read_mux = port_a_out_ff;
         REG_DDRB: read_mux = dir_b_ff;
         REG_DDRA: read_mux = dir_a_ff;
         REG_ACR:  read_mux = aux_control_ff;
         REG_PCR:  read_mux = periph_control_ff;
         REG_IFR:  read_mux = {irq_now, flag_bits_ff};
         REG_IER:  read_mux = {1'b0, enable_bits_ff};
         default:  read_mux = 8'h00;
      endcase
   end

   assign read_data = is_read ? read_mux : 8'h00;

   // The interrupt line follows the state after this transaction.
   assign irq_next = |(flag_bits_in & enable_bits_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         port_b_out_ff     <= '0;
         port_a_out_ff     <= '0;
         dir_a_ff          <= '0;
         dir_b_ff          <= '0;
         t2_latch_low_ff   <= '0;
         t2_latch_high_ff  <= '0;
         aux_control_ff    <= '0;
         periph_control_ff <= '0;
         flag_bits_ff      <= '0;
         enable_bits_ff    <= '0;
      end else begin
         port_b_out_ff     <= port_b_out_in;
         port_a_out_ff     <= port_a_out_in;
         dir_a_ff          <= dir_a_in;
         dir_b_ff          <= dir_b_in;
         t2_latch_low_ff   <= t2_latch_low_in;
         t2_latch_high_ff  <= t2_latch_high_in;
         aux_control_ff    <= aux_control_in;
         periph_control_ff <= periph_control_in;
         flag_bits_ff      <= flag_bits_in;
         enable_bits_ff    <= enable_bits_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/versatile_interface_timer2_irq.sv
// Timer 2 and interrupt subset of a 6522-style interface adapter.
// Each request transaction is a tick, a register read or a register write
// (req_op, req_reg_addr, req_write_data); each produces exactly one response
// transaction carrying rsp_read_data (zero except on reads) and rsp_irq, the
// OR of the enabled interrupt flags after the request took effect.
// A transaction moves when valid is high and stall is low on its channel.
// The register file and timer update in a single pass from the input register
// into the response register, which raises rsp_valid, once that slot frees.
// Throughput is one per cycle while the receiver does not stall.
// When the receiver stalls, the response register holds its payload; one
// more request is taken into the input register, after which req_stall rises
// until the response drains.
// Reset (synchronous, active high) empties both registers and clears all
// adapter registers and the countdown, so the first tick expires the timer.
// The countdown reloads with the 16-bit latch shifted right by PRESCALE_SHIFT.
// Depends on via_pkg, via_regs and via_timer2.
`default_nettype none

module versatile_interface_timer2_irq
   import via_pkg::*;
#(
   parameter int unsigned PRESCALE_SHIFT = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [3:0] req_reg_addr,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq
);

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_op_ff;
   logic [3:0]         in_addr_ff;
   logic [7:0]         in_data_ff;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_read_ff;
   logic               out_irq_ff;
   logic               accept;
   logic               advance;
   t2_ctl_type         t2_ctl;
   logic [LATCH_W-1:0] latch_next;
   logic               expire;
   logic [7:0]         read_data;
   logic               irq_next;

   // Handshake: the held transaction advances when the response slot frees.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_op;
         in_addr_ff <= req_reg_addr;
         in_data_ff <= req_write_data;
      end
   end

   via_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .op         (in_op_ff),
      .reg_addr   (in_addr_ff),
      .write_data (in_data_ff),
      .expire     (expire),
      .t2_ctl     (t2_ctl),
      .latch_next (latch_next),
      .read_data  (read_data),
      .irq_next   (irq_next)
   );

   via_timer2 #(
      .PRESCALE_SHIFT (PRESCALE_SHIFT)
   ) u_timer2 (
      .clock      (clock),
      .reset      (reset),
      .ctl        (t2_ctl),
      .latch_next (latch_next),
      .expire     (expire)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_read_ff <= read_data;
         out_irq_ff  <= irq_next;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_read_ff;
   assign rsp_irq       = out_irq_ff;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for versatile_interface_timer2_irq, the timer 2 and interrupt subset.
// It predicts every response with a cycle-free model of the adapter registers and the countdown.
// Depends on via_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench
   import via_pkg::*;
();

   localparam int unsigned PRESCALE    = 2;
   localparam int unsigned COUNT_W     = LATCH_W - PRESCALE;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ACCESSES = 1925;
   localparam int unsigned MAX_REPORTS = 10;

   // The op field has a fourth code that the block must treat as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Registers outside the package map: timer 1 and the shift register.
   localparam logic [3:0] REG_T1CL = 4'd4;
   localparam logic [3:0] REG_SR   = 4'd10;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] addr;
      logic [7:0] data;
   } bus_access_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
   } adapter_reply_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_TICK;
   logic [3:0] req_reg_addr = REG_ORB;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_irq;

   // Adapter state as the predictor sees it.
   logic [7:0]         port_b;
   logic [7:0]         port_a;
   logic [7:0]         ddr_a;
   logic [7:0]         ddr_b;
   logic [7:0]         t2_lo;
   logic [7:0]         t2_hi;
   logic [7:0]         acr;
   logic [7:0]         pcr;
   logic [FLAG_W-1:0]  ifr_flags;
   logic [FLAG_W-1:0]  ier_bits;
   logic [COUNT_W-1:0] countdown;

   bus_access_type    bus_access_q[$];
   adapter_reply_type expected_reply_q[$];
   bus_access_type    current_access;
   bit                offering;
   int unsigned       burst_left;
   int unsigned       gap_left;
   int unsigned       accepted_count;
   int unsigned       mismatch_count;
   int unsigned       cycle_count;
   int unsigned       hold_left;
   int unsigned       holds_done;
   int unsigned       mode_left;
   stall_mode_type    stall_mode;
   bit                stall_next;

   versatile_interface_timer2_irq #(
      .PRESCALE_SHIFT(PRESCALE)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clear the predicted adapter state, as reset does in the block.
   task automatic clear_adapter_state();
      port_b    = '0;
      port_a    = '0;
      ddr_a     = '0;
      ddr_b     = '0;
      t2_lo     = '0;
      t2_hi     = '0;
      acr       = '0;
      pcr       = '0;
      ifr_flags = '0;
      ier_bits  = '0;
      countdown = '0;
   endtask

   function automatic logic [COUNT_W-1:0] t2_reload();
      logic [LATCH_W-1:0] latch;
      latch = {t2_hi, t2_lo};
      return COUNT_W'(latch >> PRESCALE);
   endfunction

   // Apply one access to the predicted state and return the response it yields.
   function automatic adapter_reply_type adapter_apply(bus_access_type a);
      adapter_reply_type r;
      r.read_data = 8'h00;
      case (a.op)
         OP_TICK: begin
            if (countdown != 0) countdown = countdown - COUNT_W'(1);
            if (countdown == 0) begin
               countdown = t2_reload();
               if (ier_bits[T2_BIT]) ifr_flags[T2_BIT] = 1'b1;
            end
         end
         OP_READ: begin
            case (a.addr)
               REG_ORB:           r.read_data = (port_b & ORB_MASK) | ORB_FORCE;
               REG_ORA, REG_ORAN: r.read_data = port_a;
               REG_DDRB:          r.read_data = ddr_b;
               REG_DDRA:          r.read_data = ddr_a;
               REG_ACR:           r.read_data = acr;
               REG_PCR:           r.read_data = pcr;
               REG_IFR:           r.read_data = {|(ifr_flags & ier_bits), ifr_flags};
               REG_IER:           r.read_data = {1'b0, ier_bits};
               default:           r.read_data = 8'h00;
            endcase
         end
         OP_WRITE: begin
            case (a.addr)
               REG_ORB:           port_b = a.data;
               REG_ORA, REG_ORAN: port_a = a.data;
               REG_DDRB:          ddr_b = a.data;
               REG_DDRA:          ddr_a = a.data;
               REG_T2L: begin
                  t2_lo = a.data;
                  countdown = t2_reload();
               end
               REG_T2H: begin
                  t2_hi = a.data;
                  countdown = t2_reload();
                  ifr_flags[T2_BIT] = 1'b0;
               end
               REG_ACR:           acr = a.data;
               REG_PCR:           pcr = a.data;
               REG_IFR:           ifr_flags = ifr_flags & ~a.data[FLAG_W-1:0];
               REG_IER: begin
                  if (a.data[IER_SET]) ier_bits = ier_bits | a.data[FLAG_W-1:0];
                  else ier_bits = ier_bits & ~a.data[FLAG_W-1:0];
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.irq = |(ifr_flags & ier_bits);
      return r;
   endfunction

   task automatic queue_access(logic [1:0] op, logic [3:0] addr, logic [7:0] data);
      bus_access_type a;
      a.op   = op;
      a.addr = addr;
      a.data = data;
      bus_access_q.push_back(a);
   endtask

   // Random access, weighted toward ticks and the timer and interrupt registers.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int unsigned pick;
      pick   = $urandom_range(0, 99);
      a.data = 8'($urandom_range(0, 255));
      a.addr = 4'($urandom_range(0, 15));
      if (pick < 40) begin
         a.op = OP_TICK;
      end else if (pick < 68) begin
         a.op = OP_READ;
         if ($urandom_range(0, 3) == 0) a.addr = REG_IFR;
      end else if (pick < 97) begin
         a.op = OP_WRITE;
         case ($urandom_range(0, 5))
            0: a.addr = REG_T2L;
            1: begin
               // Mostly a zero high byte keeps the countdown short enough to expire often.
               a.addr = REG_T2H;
               if ($urandom_range(0, 4) != 0) a.data = 8'h00;
            end
            2: a.addr = REG_IER;
            3: a.addr = REG_IFR;
            default: ;
         endcase
      end else begin
         a.op = OP_UNUSED;
      end
      return a;
   endfunction

   // Driver: offers queued transactions in bursts and predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         offering   = 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_reply_q.push_back(adapter_apply(current_access));
            accepted_count++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (bus_access_q.size() != 0) begin
               current_access = bus_access_q.pop_front();
               offering = 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
         req_valid      <= offering;
         req_op         <= current_access.op;
         req_reg_addr   <= current_access.addr;
         req_write_data <= current_access.data;
      end
   end

   // Receiver stall pattern, with two long hold-offs that back the block up to its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  = 0;
         holds_done = 0;
         mode_left  = 0;
         stall_mode = STALL_NONE;
      end else begin
         if (hold_left == 0 && holds_done < 2 && accepted_count >= (holds_done + 1) * 600) begin
            hold_left = $urandom_range(200, 300);
            holds_done++;
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(16, 160);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            case (stall_mode)
               STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:     stall_next = 1'b0;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Monitor: checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reply_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response with none expected: read_data=%02h irq=%0b",
                        $realtime, rsp_read_data, rsp_irq);
         end else begin
            adapter_reply_type want;
            want = expected_reply_q.pop_front();
            if (rsp_read_data !== want.read_data || rsp_irq !== want.irq) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: read_data exp %02h got %02h, irq exp %0b got %0b",
                           $realtime, want.read_data, rsp_read_data, want.irq, rsp_irq);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      clear_adapter_state();
      accepted_count = 0;
      mismatch_count = 0;
      cycle_count    = 0;

      // The first tick after reset expires the timer, but with no enable it sets no flag.
      queue_access(OP_TICK,   REG_ORB,  8'h00);
      queue_access(OP_READ,   REG_IFR,  8'h00);
      // Set every enable, then clear all but timer 2.
      queue_access(OP_WRITE,  REG_IER,  8'hff);
      queue_access(OP_WRITE,  REG_IER,  8'h5f);
      // A latch below the prescale step reloads to zero, so every tick expires.
      queue_access(OP_WRITE,  REG_T2L,  8'h03);
      queue_access(OP_WRITE,  REG_T2H,  8'h00);
      queue_access(OP_TICK,   REG_ORB,  8'h00);
      queue_access(OP_READ,   REG_IFR,  8'h00);
      queue_access(OP_READ,   REG_IER,  8'h00);
      queue_access(OP_WRITE,  REG_IFR,  8'h7f);
      queue_access(OP_UNUSED, REG_ORAN, 8'hff);
      queue_access(OP_TICK,   REG_ORB,  8'h00);
      queue_access(OP_WRITE,  REG_ORB,  8'hff);
      queue_access(OP_READ,   REG_ORB,  8'h00);
      queue_access(OP_WRITE,  REG_ORAN, 8'ha5);
      queue_access(OP_READ,   REG_ORA,  8'h00);
      queue_access(OP_WRITE,  REG_DDRB, 8'hff);
      queue_access(OP_READ,   REG_DDRB, 8'h00);
      queue_access(OP_WRITE,  REG_DDRA, 8'h01);
      queue_access(OP_READ,   REG_DDRA, 8'h00);
      queue_access(OP_WRITE,  REG_ACR,  8'hff);
      // Writing the high latch byte, here ff, also clears the timer 2 flag.
      queue_access(OP_WRITE,  REG_T2H,  8'hff);
      queue_access(OP_READ,   REG_T1CL, 8'h00);
      queue_access(OP_WRITE,  REG_SR,   8'hff);
      queue_access(OP_READ,   REG_PCR,  8'h00);

      for (int i = 0; i < RANDOM_ACCESSES; i++)
         bus_access_q.push_back(random_access());

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (bus_access_q.size() != 0 || offering) @(posedge clock);
      while (expected_reply_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/via_pkg.sv
rtl/core/via_timer2.sv
rtl/core/via_regs.sv
rtl/core/versatile_interface_timer2_irq.sv
tb/testbench.sv
